// ----- sv/ptb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Types and codes shared by the timer bank controller, datapath and top level.
// ----------------------------------------------------------------------------
package ptb_pkg;

   typedef enum logic [1:0] {
      OP_ADD_PERIODIC = 2'd0,
      OP_ADD_PHASED   = 2'd1,
      OP_CHECK        = 2'd2,
      OP_QUERY        = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_ACK      = 2'd0,
      KIND_PERIODIC = 2'd1,
      KIND_PHASED   = 2'd2,
      KIND_REMAIN   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_SLOT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SINGLE,
      S_WALK_P,
      S_WALK_Q,
      S_FINISH
   } state_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] now_ms;
      logic [31:0] period_a;
      logic [31:0] period_b;
      logic [1:0]  slot_index;
   } req_data_type;

   typedef struct packed {
      kind_type    result_kind;
      status_type  status;
      logic [2:0]  fired_index;
      logic        new_phase;
      logic [31:0] remaining_ms;
      logic        is_last;
   } rsp_data_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic clr_idx;
      logic inc_idx;
      logic fire_p;
      logic fire_q;
      logic load_single;
      logic load_final;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type opcode;
      logic       p_done;
      logic       q_done;
      logic       p_fire;
      logic       q_fire;
      logic       pend_valid;
      logic       out_free;
   } stat_type;

endpackage

// ----- sv/ptb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_req_if / ptb_rsp_if
// Valid/ready channels carrying timer bank requests and result items.
// ----------------------------------------------------------------------------
interface ptb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] now_ms;
   logic [31:0] period_a;
   logic [31:0] period_b;
   logic [1:0]  slot_index;

   modport source (output valid, opcode, now_ms, period_a, period_b, slot_index,
                   input ready);
   modport sink (input valid, opcode, now_ms, period_a, period_b, slot_index,
                 output ready);
endinterface

interface ptb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [1:0]  status;
   logic [2:0]  fired_index;
   logic        new_phase;
   logic [31:0] remaining_ms;
   logic        is_last;

   modport source (output valid, result_kind, status, fired_index, new_phase,
                   remaining_ms, is_last, input ready);
   modport sink (input valid, result_kind, status, fired_index, new_phase,
                 remaining_ms, is_last, output ready);
endinterface

// ----- sv/ptb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer: takes one item, then either builds a single result or walks the
// periodic table and the two-phase table one channel per cycle, unless a fire waits for a free output.
// ----------------------------------------------------------------------------
module ptb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptb_pkg::stat_type stat,
   output ptb_pkg::cmd_type  cmd
);

   ptb_pkg::state_type state_ff;
   ptb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptb_pkg::S_IDLE: begin
            if (req_valid) state_in = ptb_pkg::S_DECODE;
         end
         ptb_pkg::S_DECODE: begin
            if (stat.opcode == ptb_pkg::OP_CHECK) state_in = ptb_pkg::S_WALK_P;
            else state_in = ptb_pkg::S_SINGLE;
         end
         ptb_pkg::S_SINGLE: begin
            if (stat.out_free) state_in = ptb_pkg::S_IDLE;
         end
         ptb_pkg::S_WALK_P: begin
            if (stat.p_done) state_in = ptb_pkg::S_WALK_Q;
         end
         ptb_pkg::S_WALK_Q: begin
            if (stat.q_done) state_in = ptb_pkg::S_FINISH;
         end
         ptb_pkg::S_FINISH: begin
            if (stat.out_free) state_in = ptb_pkg::S_IDLE;
         end
         default: begin
            state_in = ptb_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ptb_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ptb_pkg::S_DECODE: begin
         end
         ptb_pkg::S_SINGLE: begin
            cmd.load_single = stat.out_free;
         end
         ptb_pkg::S_WALK_P: begin
            // a fire pushes any held item out, so it waits for a free output while one is held
            if (stat.p_done) begin
               cmd.clr_idx = 1'b1;
            end else if (!stat.p_fire) begin
               cmd.inc_idx = 1'b1;
            end else if (!stat.pend_valid || stat.out_free) begin
               cmd.fire_p  = 1'b1;
               cmd.inc_idx = 1'b1;
            end
         end
         ptb_pkg::S_WALK_Q: begin
            if (stat.q_done) begin
            end else if (!stat.q_fire) begin
               cmd.inc_idx = 1'b1;
            end else if (!stat.pend_valid || stat.out_free) begin
               cmd.fire_q  = 1'b1;
               cmd.inc_idx = 1'b1;
            end
         end
         ptb_pkg::S_FINISH: begin
            cmd.load_final = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- sv/ptb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_dp
// Channel tables, table counts, walk index, held fire item and the output
// register of the timer bank.
// ----------------------------------------------------------------------------
module ptb_dp #(
   parameter int PERIODIC_SLOTS = 8,
   parameter int PHASED_SLOTS   = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptb_pkg::req_data_type req_data,
   input  ptb_pkg::cmd_type      cmd,
   output ptb_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ptb_pkg::rsp_data_type rsp_data
);

   localparam int MAX_SLOTS = (PERIODIC_SLOTS > PHASED_SLOTS) ? PERIODIC_SLOTS : PHASED_SLOTS;
   localparam int WALK_W    = $clog2(MAX_SLOTS + 1);
   localparam int AW        = (WALK_W > 2) ? WALK_W : 2;
   localparam int PCW       = $clog2(PERIODIC_SLOTS + 1);
   localparam int QCW       = $clog2(PHASED_SLOTS + 1);
   localparam int PAW       = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
   localparam int QAW       = (PHASED_SLOTS > 1) ? $clog2(PHASED_SLOTS) : 1;

   typedef struct packed {
      ptb_pkg::kind_type kind;
      logic [2:0]        index;
      logic              phase;
   } pend_type;

   // channel tables, contents undefined until written
   logic [31:0] p_period_ff [PERIODIC_SLOTS];
   logic [31:0] p_last_ff   [PERIODIC_SLOTS];
   logic [31:0] q_pa_ff     [PHASED_SLOTS];
   logic [31:0] q_pb_ff     [PHASED_SLOTS];
   logic [31:0] q_last_ff   [PHASED_SLOTS];
   logic        q_phase_ff  [PHASED_SLOTS];

   ptb_pkg::req_data_type req_ff, req_in;
   logic [PCW-1:0]        p_count_ff, p_count_in;
   logic [QCW-1:0]        q_count_ff, q_count_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic                  pend_valid_ff, pend_valid_in;
   pend_type              pend_ff, pend_in;
   logic                  out_valid_ff, out_valid_in;
   ptb_pkg::rsp_data_type out_ff, out_in;

   logic [PAW-1:0]        p_addr;
   logic [AW-1:0]         q_sel;
   logic [QAW-1:0]        q_addr;
   logic [31:0]           q_period;
   logic [31:0]           q_remain;
   logic                  p_fire, q_fire;
   logic                  p_full, q_full;
   logic                  slot_ok;
   logic                  out_free;
   logic                  push_pend;
   logic                  load_any;
   logic                  p_wr_add, q_wr_add;
   ptb_pkg::rsp_data_type single_rsp;
   ptb_pkg::rsp_data_type empty_rsp;

   assign p_addr   = idx_ff[PAW-1:0];
   // query reads the named slot, a check walks by index
   assign q_sel    = (req_ff.opcode == ptb_pkg::OP_QUERY) ? AW'(req_ff.slot_index) : idx_ff;
   assign q_addr   = q_sel[QAW-1:0];
   assign q_period = q_phase_ff[q_addr] ? q_pb_ff[q_addr] : q_pa_ff[q_addr];
   assign q_remain = q_period + q_last_ff[q_addr] - req_ff.now_ms;
   assign p_fire   = (req_ff.now_ms - p_last_ff[p_addr]) >= p_period_ff[p_addr];
   assign q_fire   = (req_ff.now_ms - q_last_ff[q_addr]) >= q_period;
   assign p_full   = (p_count_ff == PCW'(PERIODIC_SLOTS));
   assign q_full   = (q_count_ff == QCW'(PHASED_SLOTS));
   assign slot_ok  = AW'(req_ff.slot_index) < AW'(q_count_ff);
   assign out_free = !out_valid_ff || rsp_ready;

   assign push_pend = (cmd.fire_p || cmd.fire_q) && pend_valid_ff;
   assign load_any  = cmd.load_single || cmd.load_final || push_pend;
   assign p_wr_add  = cmd.load_single && (req_ff.opcode == ptb_pkg::OP_ADD_PERIODIC) && !p_full;
   assign q_wr_add  = cmd.load_single && (req_ff.opcode == ptb_pkg::OP_ADD_PHASED) && !q_full;

   always_comb begin
      empty_rsp             = '0;
      empty_rsp.result_kind = ptb_pkg::KIND_ACK;
      empty_rsp.status      = ptb_pkg::ST_OK;
      empty_rsp.is_last     = 1'b1;
   end

   always_comb begin
      single_rsp = empty_rsp;
      unique case (req_ff.opcode)
         ptb_pkg::OP_ADD_PERIODIC: begin
            if (p_full) single_rsp.status = ptb_pkg::ST_FULL;
            else single_rsp.fired_index = 3'(p_count_ff);
         end
         ptb_pkg::OP_ADD_PHASED: begin
            if (q_full) single_rsp.status = ptb_pkg::ST_FULL;
            else single_rsp.fired_index = 3'(q_count_ff);
         end
         ptb_pkg::OP_QUERY: begin
            single_rsp.result_kind = ptb_pkg::KIND_REMAIN;
            if (!slot_ok) begin
               single_rsp.status = ptb_pkg::ST_NO_SLOT;
            end else begin
               single_rsp.fired_index  = 3'(req_ff.slot_index);
               single_rsp.new_phase    = q_phase_ff[q_addr];
               single_rsp.remaining_ms = q_remain;
            end
         end
         ptb_pkg::OP_CHECK: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      req_in        = cmd.latch ? req_data : req_ff;
      p_count_in    = p_wr_add ? p_count_ff + PCW'(1) : p_count_ff;
      q_count_in    = q_wr_add ? q_count_ff + QCW'(1) : q_count_ff;

      idx_in = idx_ff;
      if (cmd.latch || cmd.clr_idx) idx_in = '0;
      else if (cmd.inc_idx) idx_in = idx_ff + AW'(1);

      pend_valid_in = pend_valid_ff;
      if (cmd.latch || cmd.load_final) pend_valid_in = 1'b0;
      else if (cmd.fire_p || cmd.fire_q) pend_valid_in = 1'b1;

      pend_in = pend_ff;
      if (cmd.fire_p) begin
         pend_in.kind  = ptb_pkg::KIND_PERIODIC;
         pend_in.index = 3'(idx_ff);
         pend_in.phase = 1'b0;
      end else if (cmd.fire_q) begin
         pend_in.kind  = ptb_pkg::KIND_PHASED;
         pend_in.index = 3'(idx_ff);
         pend_in.phase = ~q_phase_ff[q_addr];
      end

      out_valid_in = out_valid_ff;
      if (load_any) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;

      out_in = out_ff;
      priority if (cmd.load_single) begin
         out_in = single_rsp;
      end else if (cmd.load_final && !pend_valid_ff) begin
         out_in = empty_rsp;
      end else if (cmd.load_final || push_pend) begin
         out_in              = empty_rsp;
         out_in.result_kind  = pend_ff.kind;
         out_in.fired_index  = pend_ff.index;
         out_in.new_phase    = pend_ff.phase;
         out_in.is_last      = cmd.load_final;
      end else begin
         out_in = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_count_ff    <= '0;
         q_count_ff    <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         p_count_ff    <= p_count_in;
         q_count_ff    <= q_count_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (p_wr_add) begin
         p_period_ff[p_count_ff[PAW-1:0]] <= req_ff.period_a;
         p_last_ff[p_count_ff[PAW-1:0]]   <= '0;
      end else if (cmd.fire_p) begin
         p_last_ff[p_addr] <= req_ff.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr_add) begin
         q_pa_ff[q_count_ff[QAW-1:0]]    <= req_ff.period_a;
         q_pb_ff[q_count_ff[QAW-1:0]]    <= req_ff.period_b;
         q_last_ff[q_count_ff[QAW-1:0]]  <= '0;
         q_phase_ff[q_count_ff[QAW-1:0]] <= 1'b0;
      end else if (cmd.fire_q) begin
         q_last_ff[q_addr]  <= req_ff.now_ms;
         q_phase_ff[q_addr] <= ~q_phase_ff[q_addr];
      end
   end

   always_comb begin
      stat.opcode     = req_ff.opcode;
      stat.p_done     = (idx_ff == AW'(p_count_ff));
      stat.q_done     = (idx_ff == AW'(q_count_ff));
      stat.p_fire     = p_fire;
      stat.q_fire     = q_fire;
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = out_free;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_any |-> out_free)
      else $error("output register loaded while a result is still held");

   a_fire_p_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fire_p |-> (idx_ff < AW'(p_count_ff)))
      else $error("periodic fire beyond table count");

   a_fire_q_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fire_q |-> (idx_ff < AW'(q_count_ff)))
      else $error("two-phase fire beyond table count");

   a_pend_set: assert property (@(posedge clock) disable iff (reset)
      (cmd.fire_p || cmd.fire_q) |=> pend_valid_ff)
      else $error("fired channel not held");

   a_final_last: assert property (@(posedge clock) disable iff (reset)
      cmd.load_final |=> (out_valid_ff && out_ff.is_last))
      else $error("final item of a check not marked last");
`endif

endmodule

// ----- sv/periodic_and_two_phase_timer_bank.sv -----
`timescale 1ns / 1ps
// add and query items: accepted in S_IDLE, decoded in S_DECODE, result loaded
//   from S_SINGLE once the output is free, next item taken back in S_IDLE
// check items: walk of S_WALK_P then S_WALK_Q, last result loaded from S_FINISH
//   once the output is free, next item taken back in S_IDLE
// output stalls hold the walk only when a second fired item must be pushed
// reset clears the sequencer, walk state, counts and output valid, not the tables
// ----------------------------------------------------------------------------
// periodic_and_two_phase_timer_bank
// Bank of periodic and two-phase software timers on a 32-bit millisecond time.
// ----------------------------------------------------------------------------
module periodic_and_two_phase_timer_bank #(
   parameter int PERIODIC_SLOTS = 8,
   parameter int PHASED_SLOTS   = 4
) (
   input  logic             clock,
   input  logic             reset,
   ptb_req_if.sink          req_if,
   ptb_rsp_if.source        rsp_if
);

   ptb_pkg::req_data_type req_data;
   ptb_pkg::rsp_data_type rsp_data;
   ptb_pkg::cmd_type      cmd;
   ptb_pkg::stat_type     stat;
   logic                  rsp_valid;

   always_comb begin
      req_data.opcode     = ptb_pkg::opcode_type'(req_if.opcode);
      req_data.now_ms     = req_if.now_ms;
      req_data.period_a   = req_if.period_a;
      req_data.period_b   = req_if.period_b;
      req_data.slot_index = req_if.slot_index;
   end

   ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptb_dp #(
      .PERIODIC_SLOTS (PERIODIC_SLOTS),
      .PHASED_SLOTS   (PHASED_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.valid        = rsp_valid;
   assign rsp_if.result_kind  = rsp_data.result_kind;
   assign rsp_if.status       = rsp_data.status;
   assign rsp_if.fired_index  = rsp_data.fired_index;
   assign rsp_if.new_phase    = rsp_data.new_phase;
   assign rsp_if.remaining_ms = rsp_data.remaining_ms;
   assign rsp_if.is_last      = rsp_data.is_last;

endmodule

// ----- verif/tb_periodic_and_two_phase_timer_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_and_two_phase_timer_bank
// Drives add, check and query items into the timer bank and checks every
// result item against a cycle-free model of both timer tables. A directed
// table covers empty and full tables, period extremes, wrapped elapsed time
// and unregistered slots. Random items with a mostly advancing clock follow,
// under sender and receiver idling, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_periodic_and_two_phase_timer_bank;

   localparam int PERIODIC_SLOTS = 8;
   localparam int PHASED_SLOTS   = 4;
   localparam int LONG_HOLD      = 250;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int TAIL_CYCLES    = 40;

   typedef struct {
      ptb_pkg::req_data_type item;
      bit                    typed;
      ptb_pkg::rsp_data_type res;
   } stim_row_type;

   logic clock;
   logic reset;

   ptb_req_if req_bus ();
   ptb_rsp_if rsp_bus ();

   periodic_and_two_phase_timer_bank #(
      .PERIODIC_SLOTS (PERIODIC_SLOTS),
      .PHASED_SLOTS   (PHASED_SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // shadow copy of both timer tables
   logic [31:0] per_period [PERIODIC_SLOTS];
   logic [31:0] per_last   [PERIODIC_SLOTS];
   int          per_count;
   logic [31:0] ph_period_a [PHASED_SLOTS];
   logic [31:0] ph_period_b [PHASED_SLOTS];
   logic [31:0] ph_last     [PHASED_SLOTS];
   logic        ph_phase    [PHASED_SLOTS];
   int          ph_count;

   ptb_pkg::rsp_data_type step_results [$];
   ptb_pkg::rsp_data_type due_results [$];
   stim_row_type          stim_table [$];

   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_req;
   int          fail_count;
   int          items_sent;
   int          results_seen;
   int          fires_seen;
   logic [31:0] wall_ms;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // expected result items for one accepted item; updates the shadow tables
   function automatic void step_timer_bank(input ptb_pkg::req_data_type it);
      ptb_pkg::rsp_data_type r;
      logic [31:0]           elapsed;
      logic [31:0]           active;
      step_results.delete();
      r = '0;
      r.is_last = 1'b1;
      case (it.opcode)
         ptb_pkg::OP_ADD_PERIODIC: begin
            if (per_count >= PERIODIC_SLOTS) begin
               r.status = ptb_pkg::ST_FULL;
            end else begin
               per_period[per_count] = it.period_a;
               per_last[per_count]   = '0;
               r.fired_index         = per_count[2:0];
               per_count++;
            end
            step_results.push_back(r);
         end
         ptb_pkg::OP_ADD_PHASED: begin
            if (ph_count >= PHASED_SLOTS) begin
               r.status = ptb_pkg::ST_FULL;
            end else begin
               ph_period_a[ph_count] = it.period_a;
               ph_period_b[ph_count] = it.period_b;
               ph_last[ph_count]     = '0;
               ph_phase[ph_count]    = 1'b0;
               r.fired_index         = ph_count[2:0];
               ph_count++;
            end
            step_results.push_back(r);
         end
         ptb_pkg::OP_CHECK: begin
            for (int i = 0; i < per_count; i++) begin
               elapsed = it.now_ms - per_last[i];
               if (elapsed >= per_period[i]) begin
                  per_last[i]   = it.now_ms;
                  r             = '0;
                  r.result_kind = ptb_pkg::KIND_PERIODIC;
                  r.fired_index = i[2:0];
                  step_results.push_back(r);
               end
            end
            for (int i = 0; i < ph_count; i++) begin
               elapsed = it.now_ms - ph_last[i];
               active  = ph_phase[i] ? ph_period_b[i] : ph_period_a[i];
               if (elapsed >= active) begin
                  ph_phase[i]   = ~ph_phase[i];
                  ph_last[i]    = it.now_ms;
                  r             = '0;
                  r.result_kind = ptb_pkg::KIND_PHASED;
                  r.fired_index = i[2:0];
                  r.new_phase   = ph_phase[i];
                  step_results.push_back(r);
               end
            end
            if (step_results.size() == 0) begin
               r = '0;
               r.is_last = 1'b1;
               step_results.push_back(r);
            end else begin
               r = step_results[step_results.size() - 1];
               r.is_last = 1'b1;
               step_results[step_results.size() - 1] = r;
            end
         end
         default: begin
            r.result_kind = ptb_pkg::KIND_REMAIN;
            if (int'(it.slot_index) >= ph_count) begin
               r.status = ptb_pkg::ST_NO_SLOT;
            end else begin
               active         = ph_phase[it.slot_index] ? ph_period_b[it.slot_index]
                                                        : ph_period_a[it.slot_index];
               r.fired_index  = {1'b0, it.slot_index};
               r.new_phase    = ph_phase[it.slot_index];
               r.remaining_ms = active + ph_last[it.slot_index] - it.now_ms;
            end
            step_results.push_back(r);
         end
      endcase
   endfunction

   function automatic ptb_pkg::rsp_data_type lone_result(input ptb_pkg::kind_type k,
                                                         input ptb_pkg::status_type s,
                                                         input logic [2:0] idx);
      ptb_pkg::rsp_data_type r;
      r = '0;
      r.result_kind = k;
      r.status      = s;
      r.fired_index = idx;
      r.is_last     = 1'b1;
      return r;
   endfunction

   function automatic void table_row(input ptb_pkg::opcode_type op, input logic [31:0] now,
                                     input logic [31:0] pa, input logic [31:0] pb,
                                     input logic [1:0] slot, input bit typed = 1'b0,
                                     input ptb_pkg::rsp_data_type res = '0);
      stim_row_type row;
      row.item.opcode     = op;
      row.item.now_ms     = now;
      row.item.period_a   = pa;
      row.item.period_b   = pb;
      row.item.slot_index = slot;
      row.typed           = typed;
      row.res             = res;
      stim_table.push_back(row);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic offer(input ptb_pkg::req_data_type it, input bit typed,
                        input ptb_pkg::rsp_data_type res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= it.opcode;
      req_bus.now_ms     <= it.now_ms;
      req_bus.period_a   <= it.period_a;
      req_bus.period_b   <= it.period_b;
      req_bus.slot_index <= it.slot_index;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      step_timer_bank(it);
      if (typed) begin
         due_results.push_back(res);
      end else begin
         foreach (step_results[k]) due_results.push_back(step_results[k]);
      end
      items_sent++;
   endtask

   // mostly a steadily advancing clock, with some jumps and wild times
   task automatic send_random(input int count);
      ptb_pkg::req_data_type it;
      int                    sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 60)      it.opcode = ptb_pkg::OP_CHECK;
         else if (sel < 85) it.opcode = ptb_pkg::OP_QUERY;
         else if (sel < 92) it.opcode = ptb_pkg::OP_ADD_PERIODIC;
         else               it.opcode = ptb_pkg::OP_ADD_PHASED;
         sel = $urandom_range(0, 99);
         if (sel < 85)      wall_ms = wall_ms + $urandom_range(0, 40);
         else if (sel < 95) wall_ms = wall_ms + $urandom_range(0, 2000);
         else               wall_ms = $urandom;
         it.now_ms     = wall_ms;
         it.period_a   = $urandom;
         it.period_b   = $urandom;
         it.slot_index = 2'($urandom_range(0, 3));
         offer(it, 1'b0, '0);
      end
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      for (int c = 0; c < DRAIN_LIMIT && due_results.size() != 0; c++) @(posedge clock);
   endtask

   // receiver side; a long hold is counted here
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      ptb_pkg::rsp_data_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (rsp_bus.result_kind == ptb_pkg::KIND_PERIODIC ||
             rsp_bus.result_kind == ptb_pkg::KIND_PHASED)
            fires_seen++;
         if (due_results.size() == 0) begin
            $error("result item arrived with nothing pending");
            fail_count++;
         end else begin
            want = due_results.pop_front();
            check_field("result_kind", want.result_kind, rsp_bus.result_kind);
            check_field("status", want.status, rsp_bus.status);
            check_field("fired_index", want.fired_index, rsp_bus.fired_index);
            check_field("new_phase", want.new_phase, rsp_bus.new_phase);
            check_field("remaining_ms", want.remaining_ms, rsp_bus.remaining_ms);
            check_field("is_last", want.is_last, rsp_bus.is_last);
         end
      end
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= ptb_pkg::OP_ADD_PERIODIC;
      req_bus.now_ms     <= '0;
      req_bus.period_a   <= '0;
      req_bus.period_b   <= '0;
      req_bus.slot_index <= '0;
      hold_req      = 1'b0;
      fail_count    = 0;
      items_sent    = 0;
      results_seen  = 0;
      fires_seen    = 0;
      wall_ms       = '0;
      per_count     = 0;
      ph_count      = 0;
      send_idle_pct = 38;
      recv_idle_pct = 45;

      // empty tables
      table_row(ptb_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_REMAIN, ptb_pkg::ST_NO_SLOT, 3'd0));
      table_row(ptb_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd0));
      // fill the periodic table, period extremes included
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 2'd3, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd0));
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'd0, 32'hFFFF_FFFF, 32'd0, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd1));
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'd12, 32'd1, 32'd9, 2'd1, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd2));
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'd0, 32'd3, 32'd0, 2'd2, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd3));
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'd0, 32'd7, 32'd0, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd4));
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'd0, 32'd20, 32'd0, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd5));
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'd0, 32'd64, 32'd0, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd6));
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'd0, 32'h8000_0000, 32'd0, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd7));
      table_row(ptb_pkg::OP_ADD_PERIODIC, 32'd0, 32'd5, 32'd0, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_FULL, 3'd0));
      // two-phase table, with a query of a slot not yet added
      table_row(ptb_pkg::OP_ADD_PHASED, 32'd0, 32'd10, 32'd20, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd0));
      table_row(ptb_pkg::OP_ADD_PHASED, 32'd0, 32'd0, 32'hFFFF_FFFF, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd1));
      table_row(ptb_pkg::OP_QUERY, 32'd7, 32'd0, 32'd0, 2'd2, 1'b1,
                lone_result(ptb_pkg::KIND_REMAIN, ptb_pkg::ST_NO_SLOT, 3'd0));
      table_row(ptb_pkg::OP_ADD_PHASED, 32'd0, 32'hFFFF_FFFF, 32'd0, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd2));
      table_row(ptb_pkg::OP_ADD_PHASED, 32'd0, 32'd5, 32'd13, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_OK, 3'd3));
      table_row(ptb_pkg::OP_ADD_PHASED, 32'd0, 32'd1, 32'd1, 2'd0, 1'b1,
                lone_result(ptb_pkg::KIND_ACK, ptb_pkg::ST_FULL, 3'd0));
      // queries and checks, wrapped and overdue times included
      table_row(ptb_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0, 2'd0);
      table_row(ptb_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0, 2'd2);
      table_row(ptb_pkg::OP_CHECK, 32'd0, 32'd0, 32'd0, 2'd0);
      table_row(ptb_pkg::OP_QUERY, 32'd5, 32'd0, 32'd0, 2'd1);
      table_row(ptb_pkg::OP_CHECK, 32'h8000_0000, 32'd0, 32'd0, 2'd0);
      table_row(ptb_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'd0, 32'd0, 2'd0);
      table_row(ptb_pkg::OP_QUERY, 32'd3, 32'd0, 32'd0, 2'd3);
      table_row(ptb_pkg::OP_CHECK, 32'd0, 32'd0, 32'd0, 2'd0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[k]) offer(stim_table[k].item, stim_table[k].typed, stim_table[k].res);

      send_random(130);

      // output held off while the sender keeps pushing, then a full drain
      send_idle_pct = 0;
      hold_req      = 1'b1;
      send_random(24);
      wait_for_results();

      send_idle_pct = 45;
      recv_idle_pct = 38;
      send_random(120);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(81);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("%0d result items never arrived", due_results.size());
         fail_count++;
      end

      $display("covered %0d items and %0d result items, %0d of them timer fires",
               items_sent, results_seen, fires_seen);
      $display("full and empty tables, wrapped time, overdue and unregistered queries");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
